@@ design/assert_macros.svh @@
// Assertion helpers for the sample stats block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with no reset disable.
`define SWS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sws_pkg.sv @@
`timescale 1ns / 1ps

package sws_pkg;

    localparam int WIN_W   = 7;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // store port controls
    typedef struct packed {
        logic we;
        logic re;
    } store_ctrl_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/windowed_sample_stats_top.sv @@
`timescale 1ns / 1ps

// Windowed sample statistics. Push and clear transactions leave the block in
// its idle state, so it is ready again on the next cycle. A query walks the
// last W entries of the ring store (W = min(effective window, total count)),
// one store read per cycle through the single registered read port, then
// runs a restoring divider at one quotient bit per cycle to form the mean.
// A query occupies the block through the walk and the divide, whose dividend
// is SUM_W = SAMPLE_WIDTH + clog2(STORE_DEPTH + 1) bits wide (31 at the
// defaults); when no valid sample is in the window the divide is skipped.
// in_ready is low for the whole query. The result sits in an output register,
// so pushes may go on while it waits for out_ready. The store needs no
// clearing pass after reset. window_size is written through cfg_we/cfg_wdata;
// zero or a value above STORE_DEPTH selects the full store.
module windowed_sample_stats_top #(
    parameter int STORE_DEPTH  = 64,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [sws_pkg::WIN_W-1:0]      cfg_wdata,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sws_pkg::OP_W-1:0]       opcode,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           sample_valid,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           data_present,
    output logic signed [SAMPLE_WIDTH-1:0] minimum,
    output logic signed [SAMPLE_WIDTH-1:0] maximum,
    output logic signed [SAMPLE_WIDTH-1:0] mean,
    output logic signed [SAMPLE_WIDTH-1:0] latest,
    output logic [sws_pkg::WIN_W-1:0]      window_count,
    output logic [sws_pkg::COUNT_W-1:0]    total_count
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int WC_W  = $clog2(STORE_DEPTH + 1);     // holds W and n
    localparam int SUM_W = SAMPLE_WIDTH + WC_W;
    localparam int ENT_W = SAMPLE_WIDTH + 1;            // valid bit + sample

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0] state_reg, state_next;

    // architectural state
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [sws_pkg::COUNT_W-1:0]   total_reg, total_next;
    logic [sws_pkg::WIN_W-1:0]     window_size_reg;

    // query walk
    logic [WC_W-1:0]               w_reg, w_next;
    logic [WC_W-1:0]               idx_reg, idx_next;
    logic [AW-1:0]                 raddr_reg, raddr_next;
    logic                          pend_reg, pend_next;

    // running statistics
    logic signed [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic signed [SAMPLE_WIDTH-1:0] last_reg, last_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic [WC_W-1:0]                n_reg, n_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic                           data_present_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_out_reg, max_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] mean_out_reg, last_out_reg;
    logic [sws_pkg::WIN_W-1:0]      wcount_out_reg;
    logic [sws_pkg::COUNT_W-1:0]    total_out_reg;
    logic                           out_load;

    // store and divider hookup
    sws_pkg::store_ctrl_t           st_ctrl;
    logic [ENT_W-1:0]               st_rdata;
    logic                           div_start;
    logic [SUM_W-1:0]               div_num;
    logic [SUM_W-1:0]               div_quo;
    sws_pkg::div_stat_t             div_stat;

    logic                           in_fire;
    logic                           push_fire;
    logic [WC_W-1:0]                win_eff;
    logic [WC_W-1:0]                w_calc;
    logic [AW:0]                    start_calc;
    logic [AW:0]                    wp_ext;
    logic [AW:0]                    w_ext;
    logic                           issue;
    logic                           rd_ok;
    logic signed [SAMPLE_WIDTH-1:0] rd_val;
    logic signed [SUM_W-1:0]        rd_val_ext;
    logic                           sum_neg;
    logic [SUM_W-1:0]               mean_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign push_fire = in_fire & (opcode == sws_pkg::OP_PUSH);

    // Effective window: zero or oversize selects the full store.
    always_comb
    begin
        if (window_size_reg == '0 || 32'(window_size_reg) > STORE_DEPTH)
        begin
            win_eff = WC_W'(STORE_DEPTH);
        end
        else
        begin
            win_eff = WC_W'(window_size_reg);
        end
        w_calc = (total_reg < 32'(win_eff)) ? WC_W'(total_reg) : win_eff;
    end

    // Oldest entry of the window, wrapping modulo STORE_DEPTH.
    always_comb
    begin
        wp_ext = {1'b0, wp_reg};
        w_ext  = (AW+1)'(w_calc);
        if (wp_ext >= w_ext)
        begin
            start_calc = wp_ext - w_ext;
        end
        else
        begin
            start_calc = wp_ext + (AW+1)'(STORE_DEPTH) - w_ext;
        end
    end

    assign issue      = (state_reg == ST_WALK) && (idx_reg != w_reg);
    assign rd_ok      = st_rdata[SAMPLE_WIDTH];
    assign rd_val     = st_rdata[SAMPLE_WIDTH-1:0];
    assign rd_val_ext = {{(SUM_W-SAMPLE_WIDTH){rd_val[SAMPLE_WIDTH-1]}}, rd_val};

    assign sum_neg = sum_reg[SUM_W-1];
    assign div_num = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // Sign restore gives truncation toward zero.
    assign mean_full = sum_neg ? (~div_quo + SUM_W'(1)) : div_quo;

    assign st_ctrl.we = push_fire;
    assign st_ctrl.re = issue;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        total_next     = total_reg;
        w_next         = w_reg;
        idx_next       = idx_reg;
        raddr_next     = raddr_reg;
        pend_next      = 1'b0;
        min_next       = min_reg;
        max_next       = max_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        sws_pkg::OP_PUSH:
                        begin
                            wp_next = (wp_reg == AW'(STORE_DEPTH - 1)) ? '0
                                                                        : wp_reg + AW'(1);
                            if (total_reg != sws_pkg::COUNT_MAX)
                            begin
                                total_next = total_reg + 32'd1;
                            end
                        end
                        sws_pkg::OP_QUERY:
                        begin
                            w_next     = w_calc;
                            idx_next   = '0;
                            raddr_next = start_calc[AW-1:0];
                            min_next   = '0;
                            max_next   = '0;
                            last_next  = '0;
                            sum_next   = '0;
                            n_next     = '0;
                            state_next = ST_WALK;
                        end
                        sws_pkg::OP_CLEAR:
                        begin
                            wp_next    = '0;
                            total_next = '0;
                        end
                        default:
                        begin
                            // unused opcode: no effect
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (issue)
                begin
                    idx_next   = idx_reg + WC_W'(1);
                    raddr_next = (raddr_reg == AW'(STORE_DEPTH - 1)) ? '0
                                                                     : raddr_reg + AW'(1);
                    pend_next  = 1'b1;
                end

                // fold in the entry read last cycle
                if (pend_reg && rd_ok)
                begin
                    if (n_reg == '0 || rd_val < min_reg)
                    begin
                        min_next = rd_val;
                    end
                    if (n_reg == '0 || rd_val > max_reg)
                    begin
                        max_next = rd_val;
                    end
                    sum_next  = sum_reg + rd_val_ext;
                    last_next = rd_val;
                    n_next    = n_reg + WC_W'(1);
                end

                if (!issue && !pend_reg)
                begin
                    if (n_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wp_reg          <= '0;
            total_reg       <= '0;
            window_size_reg <= sws_pkg::WINDOW_RESET;
            pend_reg        <= 1'b0;
            idx_reg         <= '0;
            w_reg           <= '0;
            n_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            w_reg         <= w_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
        last_reg  <= last_next;
        sum_reg   <= sum_next;
        if (out_load)
        begin
            data_present_reg <= (n_reg != '0);
            min_out_reg      <= min_reg;
            max_out_reg      <= max_reg;
            last_out_reg     <= last_reg;
            mean_out_reg     <= (n_reg != '0) ? mean_full[SAMPLE_WIDTH-1:0] : '0;
            wcount_out_reg   <= sws_pkg::WIN_W'(w_reg);
            total_out_reg    <= total_reg;
        end
    end

    sws_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (ENT_W)
    ) u_store (
        .clk   (clk),
        .ctrl  (st_ctrl),
        .waddr (wp_reg),
        .wdata ({sample_valid, sample}),
        .raddr (raddr_reg),
        .rdata (st_rdata)
    );

    sws_divider #(
        .NUM_W (SUM_W),
        .DEN_W (WC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (n_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    assign out_valid    = out_valid_reg;
    assign data_present = data_present_reg;
    assign minimum      = min_out_reg;
    assign maximum      = max_out_reg;
    assign mean         = mean_out_reg;
    assign latest       = last_out_reg;
    assign window_count = wcount_out_reg;
    assign total_count  = total_out_reg;

endmodule

@@ design/sws_store.sv @@
`timescale 1ns / 1ps

module sws_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 25
) (
    input  logic                     clk,
    input  sws_pkg::store_ctrl_t     ctrl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sws_divider.sv @@
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module sws_divider #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output sws_pkg::div_stat_t   status
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = ~diff[DEN_W];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ design/sws_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sws_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [sws_pkg::OP_W-1:0]       opcode,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           data_present,
    input logic signed [SAMPLE_WIDTH-1:0] minimum,
    input logic signed [SAMPLE_WIDTH-1:0] maximum,
    input logic signed [SAMPLE_WIDTH-1:0] mean,
    input logic signed [SAMPLE_WIDTH-1:0] latest
);

    logic query_fire;
    logic stats_zero;
    logic stats_ordered;

    assign query_fire    = in_valid && in_ready && (opcode == sws_pkg::OP_QUERY);
    assign stats_zero    = (minimum == '0) && (maximum == '0) && (mean == '0)
                           && (latest == '0);
    assign stats_ordered = (minimum <= maximum) && (minimum <= mean) && (mean <= maximum)
                           && (minimum <= latest) && (latest <= maximum);

    // stalled result transaction stays offered
    `SWS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // a query transaction occupies the block
    `SWS_ASSERT(a_query_busy, query_fire |=> !in_ready, "ready right after query")

    // empty window reports zeros
    `SWS_ASSERT(a_empty_zero, out_valid && !data_present |-> stats_zero, "nonzero stats, no data")

    // statistics ordered
    `SWS_ASSERT(a_order, out_valid && data_present |-> stats_ordered, "statistics out of order")

endmodule

bind windowed_sample_stats_top sws_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sws_checker (.*);

@@ bench/tb_windowed_sample_stats_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for windowed_sample_stats_top.
//
// A scoreboard object keeps its own copy of the ring store, write pointer,
// saturating push count and window register. Every accepted input transaction
// is replayed into that copy. A query turns into one expected statistics
// record, queued in order. Every result the block hands over is popped
// against the oldest record, field by field.
//
// Sender: bursts of random length separated by random gaps. Receiver: its own
// out_ready pattern (always ready, random, sparse, hard stall). The window
// register is only rewritten with the block idle: no query outstanding, plus
// a settle time longer than the slowest query.
module tb_windowed_sample_stats_top;

    localparam int DEPTH       = 64;
    localparam int SW          = 24;
    localparam int CLK_PERIOD  = 8;
    // Longer than a full-window query: a walk over all 64 entries, the 31-step divide and overhead.
    localparam int SETTLE      = 128;
    localparam int PHASE_ITEMS = 206;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Opcode 3 has no meaning; the block must swallow it.
    localparam logic [sws_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [SW-1:0] S_MAX = 24'sh7F_FFFF;
    localparam logic signed [SW-1:0] S_MIN = 24'sh80_0000;

    // One query answer.
    typedef struct {
        logic                            data_present;
        logic signed [SW-1:0]            minimum;
        logic signed [SW-1:0]            maximum;
        logic signed [SW-1:0]            mean;
        logic signed [SW-1:0]            latest;
        logic [sws_pkg::WIN_W-1:0]       window_count;
        logic [sws_pkg::COUNT_W-1:0]     total_count;
    } stats_t;

    // Mirror of the block's state plus the queue of pending query answers.
    class stats_scoreboard;
        bit                          ring_valid [DEPTH];
        logic signed [SW-1:0]        ring_value [DEPTH];
        int unsigned                 head;
        logic [sws_pkg::COUNT_W-1:0] pushed_total;
        logic [sws_pkg::WIN_W-1:0]   window_reg;
        stats_t                      expected_stats [$];
        int unsigned                 fail_count;

        function new();
            head         = 0;
            pushed_total = '0;
            window_reg   = sws_pkg::WINDOW_RESET;
            fail_count   = 0;
        endfunction

        function void set_window(logic [sws_pkg::WIN_W-1:0] w);
            window_reg = w;
        endfunction

        function int unsigned pending();
            return expected_stats.size();
        endfunction

        // Replay one accepted input transaction.
        function void note_transaction(logic [sws_pkg::OP_W-1:0] op,
                                       logic signed [SW-1:0] s, logic v);
            int unsigned span;
            int unsigned covered;
            int unsigned start;
            int unsigned idx;
            int unsigned hits;
            longint      acc;
            longint      val;
            longint      lo;
            longint      hi;
            longint      last;
            stats_t      r;
            case (op)
                sws_pkg::OP_PUSH:
                begin
                    ring_valid[head] = v;
                    ring_value[head] = s;
                    head = (head + 1) % DEPTH;
                    if (pushed_total != sws_pkg::COUNT_MAX)
                        pushed_total++;
                end
                sws_pkg::OP_CLEAR:
                begin
                    head         = 0;
                    pushed_total = '0;
                end
                sws_pkg::OP_QUERY:
                begin
                    // zero or oversize window means the whole store
                    span = (window_reg == 0 || window_reg > DEPTH) ? DEPTH : window_reg;
                    covered = (pushed_total < span) ? pushed_total : span;
                    start = (head + DEPTH - covered) % DEPTH;
                    hits = 0;
                    acc  = 0;
                    lo   = 0;
                    hi   = 0;
                    last = 0;
                    // oldest first, so "last" ends on the newest valid entry
                    for (int k = 0; k < covered; k++)
                    begin
                        idx = (start + k) % DEPTH;
                        if (ring_valid[idx])
                        begin
                            val = longint'(ring_value[idx]);
                            if (hits == 0 || val < lo) lo = val;
                            if (hits == 0 || val > hi) hi = val;
                            acc  += val;
                            last  = val;
                            hits++;
                        end
                    end
                    r.data_present = (hits != 0);
                    r.minimum      = (hits != 0) ? SW'(lo) : '0;
                    r.maximum      = (hits != 0) ? SW'(hi) : '0;
                    // signed 64-bit divide truncates toward zero
                    r.mean         = (hits != 0) ? SW'(acc / longint'(hits)) : '0;
                    r.latest       = (hits != 0) ? SW'(last) : '0;
                    r.window_count = covered[sws_pkg::WIN_W-1:0];
                    r.total_count  = pushed_total;
                    expected_stats.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic signed [63:0] want,
                                    logic signed [63:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0d, actual %0d", field, want, seen);
                fail_count++;
            end
        endfunction

        function void check_result(stats_t seen);
            stats_t want;
            if (expected_stats.size() == 0)
            begin
                $error("result transaction with no query outstanding");
                fail_count++;
                return;
            end
            want = expected_stats.pop_front();
            compare_field("data_present", want.data_present, seen.data_present);
            compare_field("minimum",      want.minimum,      seen.minimum);
            compare_field("maximum",      want.maximum,      seen.maximum);
            compare_field("mean",         want.mean,         seen.mean);
            compare_field("latest",       want.latest,       seen.latest);
            compare_field("window_count", want.window_count, seen.window_count);
            compare_field("total_count",  want.total_count,  seen.total_count);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sws_pkg::WIN_W-1:0]       cfg_wdata;
    logic                            in_valid;
    logic                            in_ready;
    logic [sws_pkg::OP_W-1:0]        opcode;
    logic signed [SW-1:0]            sample;
    logic                            sample_valid;
    logic                            out_valid;
    logic                            out_ready;
    logic                            data_present;
    logic signed [SW-1:0]            minimum;
    logic signed [SW-1:0]            maximum;
    logic signed [SW-1:0]            mean;
    logic signed [SW-1:0]            latest;
    logic [sws_pkg::WIN_W-1:0]       window_count;
    logic [sws_pkg::COUNT_W-1:0]     total_count;

    stats_scoreboard sb = new();
    int unsigned     cycles_run = 0;

    windowed_sample_stats_top #(
        .STORE_DEPTH  (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .sample       (sample),
        .sample_valid (sample_valid),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_present (data_present),
        .minimum      (minimum),
        .maximum      (maximum),
        .mean         (mean),
        .latest       (latest),
        .window_count (window_count),
        .total_count  (total_count)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: far above the slowest legal run (every item a full-window
    // query with the longest receiver stall and sender gap).
    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("windowed_sample_stats_top regression: fail");
            $finish;
        end
    end

    // Result side: values read right after the edge are the pre-edge ones,
    // so a transaction is exactly out_valid && out_ready as the block saw it.
    always @(posedge clk)
    begin : result_monitor
        stats_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.data_present = data_present;
            seen.minimum      = minimum;
            seen.maximum      = maximum;
            seen.mean         = mean;
            seen.latest       = latest;
            seen.window_count = window_count;
            seen.total_count  = total_count;
            sb.check_result(seen);
        end
    end

    // Receiver back-pressure: stretches of one behavior at a time.
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= 1'b0;
                endcase
            end
        end
    end

    // Present one transaction and hold it until the block takes it. Called at
    // a rising edge; returns at the edge of acceptance, so the next call may
    // keep in_valid high without a second assignment in the same step.
    task automatic send_item(input logic [sws_pkg::OP_W-1:0] op,
                             input logic signed [SW-1:0] s, input logic v);
        in_valid     <= 1'b1;
        opcode       <= op;
        sample       <= s;
        sample_valid <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_transaction(op, s, v);
    endtask

    // Idle the sender; the gap is never empty, so in_valid really drops.
    task automatic sender_gap();
        int unsigned gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Quiet point: no query outstanding, then long enough for any query
    // still in the walk to finish.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [sws_pkg::WIN_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_window(w);
    endtask

    // Random transaction: mostly pushes with queries mixed in, rare clears,
    // a few spare opcodes. Samples lean toward small values and the rails.
    function automatic void pick_item(output logic [sws_pkg::OP_W-1:0] op,
                                      output logic signed [SW-1:0] s, output logic v);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 79)      op = sws_pkg::OP_PUSH;
        else if (roll < 95) op = sws_pkg::OP_QUERY;
        else if (roll < 97) op = sws_pkg::OP_CLEAR;
        else                op = OP_SPARE;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = SW'($urandom());
            4, 5, 6:    s = SW'(int'($urandom_range(0, 400)) - 200);
            7:          s = ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
            8:          s = S_MAX - SW'($urandom_range(0, 3));
            default:    s = S_MIN + SW'($urandom_range(0, 3));
        endcase
        v = ($urandom_range(0, 9) < 8);
    endfunction

    task automatic run_random(input int unsigned n_items);
        int unsigned                counted;
        int unsigned                burst;
        logic [sws_pkg::OP_W-1:0]   op;
        logic signed [SW-1:0]       s;
        logic                       v;
        counted = 0;
        while (counted < n_items)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                pick_item(op, s, v);
                send_item(op, s, v);
                if (op != OP_SPARE)
                    counted++;
            end
            sender_gap();
        end
    endtask

    initial
    begin : stimulus
        logic [sws_pkg::WIN_W-1:0] phase_windows [7];
        phase_windows = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd63};

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        opcode       = sws_pkg::OP_PUSH;
        sample       = '0;
        sample_valid = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, window at its reset value.
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // empty store
        send_item(sws_pkg::OP_PUSH,  S_MAX, 1'b1);
        send_item(sws_pkg::OP_PUSH,  S_MIN, 1'b1);
        send_item(sws_pkg::OP_PUSH,  SW'($urandom()), 1'b0); // missing reading
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // both rails, mean rounds to zero
        send_item(OP_SPARE, SW'($urandom()), 1'b1);          // ignored opcode
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);
        send_item(sws_pkg::OP_CLEAR, SW'($urandom()), 1'b1);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // empty after clear
        send_item(sws_pkg::OP_PUSH,  24'sd5, 1'b0);
        send_item(sws_pkg::OP_PUSH,  -24'sd7, 1'b0);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // only missing readings
        send_item(sws_pkg::OP_PUSH,  -24'sd3, 1'b1);
        send_item(sws_pkg::OP_PUSH,  -24'sd2, 1'b1);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // negative mean truncates toward zero
        send_item(sws_pkg::OP_PUSH,  S_MAX, 1'b1);
        send_item(sws_pkg::OP_PUSH,  S_MAX, 1'b1);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);              // sum wider than a sample
        send_item(sws_pkg::OP_PUSH,  S_MIN, 1'b1);
        send_item(sws_pkg::OP_PUSH,  S_MIN, 1'b1);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);
        send_item(OP_SPARE, SW'($urandom()), 1'b0);
        send_item(sws_pkg::OP_CLEAR, '0, 1'b0);
        send_item(sws_pkg::OP_QUERY, '0, 1'b0);
        in_valid <= 1'b0;

        // Random phases, each under its own window setting; the last one
        // draws the window at random.
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            write_window((p < 7) ? phase_windows[p]
                                 : sws_pkg::WIN_W'($urandom_range(0, 127)));
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.fail_count == 0)
            $display("windowed_sample_stats_top regression: pass");
        else
            $display("windowed_sample_stats_top regression: fail");
        $finish;
    end

endmodule

@@ windowed_sample_stats_top.f @@
+incdir+design
design/sws_pkg.sv
design/sws_store.sv
design/sws_divider.sv
design/windowed_sample_stats_top.sv
design/sws_checker.sv
bench/tb_windowed_sample_stats_top.sv
